FILE: src/ptrp_pkg.sv
package ptrp_pkg;

  localparam logic [15:0] FRAME_MAGIC = 16'h5253;
  localparam logic [7:0]  VER_PLAIN   = 8'd1;
  localparam logic [7:0]  VER_STYLE   = 8'd2;
  localparam logic [7:0]  HDR_BYTES   = 8'd4;

  localparam logic [1:0] CFG_STALE = 2'd0;
  localparam logic [1:0] CFG_HYST  = 2'd1;
  localparam logic [1:0] CFG_MOOD  = 2'd2;

  localparam logic [1:0] ST_FOUND  = 2'd0;
  localparam logic [1:0] ST_NONE   = 2'd1;
  localparam logic [1:0] ST_ACCEPT = 2'd2;
  localparam logic [1:0] ST_REJECT = 2'd3;

  localparam logic CMD_RX    = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef struct packed {
    logic              command;
    logic [31:0]       now_ms;
    logic [47:0]       src_mac;
    logic [15:0]       header_magic;
    logic [7:0]        header_version;
    logic [7:0]        mood_code;
    logic [39:0]       style_bytes;
    logic [7:0]        frame_len;
    logic signed [7:0] rx_rssi;
  } in_word_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [47:0]       peer_mac;
    logic [7:0]        peer_mood;
    logic              peer_has_style;
    logic [2:0]        tone_idx;
    logic [2:0]        hair_idx;
    logic [2:0]        iris_idx;
    logic [1:0]        beard_idx;
    logic              glasses;
    logic signed [7:0] peer_rssi;
    logic [31:0]       peer_age_ms;
  } out_word_t;

  // One style byte: zero when beyond the frame or at or above its count.
  function automatic logic [2:0] clamp_field(input logic [39:0] bytes, input int k,
                                             input logic [7:0] flen,
                                             input logic [7:0] count);
    logic [7:0] v;
    v = bytes[8*k +: 8];
    if ({1'b0, flen} < {1'b0, HDR_BYTES} + 9'(k) + 9'd1) return 3'd0;
    if (v < count) return v[2:0];
    return 3'd0;
  endfunction

endpackage

FILE: src/ptrp_check.sv
// Checks the frame header and packs the style bits of a received frame.
module ptrp_check (
  input  ptrp_pkg::in_word_t in_i,
  input  logic [7:0]         mood_kind_count_i,
  output logic               reject_o,
  output logic [12:0]        style_o
);
  always_comb begin
    reject_o = (in_i.frame_len < ptrp_pkg::HDR_BYTES)
            || (in_i.header_magic != ptrp_pkg::FRAME_MAGIC)
            || ((in_i.header_version != ptrp_pkg::VER_PLAIN)
                && (in_i.header_version != ptrp_pkg::VER_STYLE))
            || (in_i.mood_code >= mood_kind_count_i);
    style_o = '0;
    if (in_i.header_version == ptrp_pkg::VER_STYLE && in_i.frame_len > ptrp_pkg::HDR_BYTES) begin
      style_o[0]     = 1'b1;
      style_o[3:1]   = ptrp_pkg::clamp_field(in_i.style_bytes, 0, in_i.frame_len, 8'd6);
      style_o[6:4]   = ptrp_pkg::clamp_field(in_i.style_bytes, 1, in_i.frame_len, 8'd6);
      style_o[9:7]   = ptrp_pkg::clamp_field(in_i.style_bytes, 2, in_i.frame_len, 8'd6);
      style_o[11:10] = 2'(ptrp_pkg::clamp_field(in_i.style_bytes, 3, in_i.frame_len, 8'd4));
      style_o[12]    = ptrp_pkg::clamp_field(in_i.style_bytes, 4, in_i.frame_len, 8'd2) != 3'd0;
    end
  end
endmodule

FILE: src/peer_table_rssi_pairing.sv
// Steps: a rejected frame goes from acceptance straight to the output step; an
// accepted frame or a query takes one scan step per slot,
// then the write, finish and output steps.
// Flow: one word at a time; the next word enters at best in the cycle
// the previous result word is taken.
// Reset: slot valid bits and the pair are cleared; control and config regs take defaults.
module peer_table_rssi_pairing #(
  parameter int PEER_SLOTS = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  ptrp_pkg::in_word_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output ptrp_pkg::out_word_t  out_data_o,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_idx_i,
  input  logic [31:0]          cfg_data_i
);
  localparam int IW = (PEER_SLOTS > 1) ? $clog2(PEER_SLOTS) : 1;
  localparam int CW = $clog2(PEER_SLOTS + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_WRITE = 3'd2;
  localparam logic [2:0] S_FIN  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0] state_q, state_d;
  logic [31:0] stale_q;
  logic [6:0]  hyst_q;
  logic [7:0]  moodk_q;

  // Slot storage: registers, each read only through the one scan index or the pair index.
  logic [PEER_SLOTS-1:0] valid_q;
  logic [47:0] mac_q  [PEER_SLOTS];
  logic [7:0]  mood_q [PEER_SLOTS];
  logic signed [7:0] rssi_q [PEER_SLOTS];
  logic [12:0] style_q [PEER_SLOTS];
  logic [31:0] seen_q [PEER_SLOTS];
  logic          pair_ok_q;
  logic [IW-1:0] pair_q;

  ptrp_pkg::in_word_t in_q;
  logic [12:0] style_in_q;
  logic [CW-1:0] cnt_q;
  logic [IW-1:0] idx;
  // Scan results.
  logic hit_q, free_q, best_ok_q;
  logic [IW-1:0] hit_idx_q, free_idx_q, old_idx_q, best_idx_q;
  logic [31:0] old_t_q, best_age_q;
  logic signed [7:0] best_r_q;
  logic pair_fresh_q;

  logic out_valid_q;
  ptrp_pkg::out_word_t out_q;

  logic reject;
  logic [12:0] style_w;
  ptrp_check u_check (.in_i(in_data_i), .mood_kind_count_i(moodk_q),
                      .reject_o(reject), .style_o(style_w));

  assign idx = cnt_q[IW-1:0];
  assign in_ready_o = (state_q == S_IDLE) && !(out_valid_q && !out_ready_i);
  assign out_valid_o = out_valid_q;
  assign out_data_o = out_q;

  // The scan compare unit: freshness and age of the slot under the scan index.
  logic [31:0] age_s;
  logic fresh_s;
  assign age_s = in_q.now_ms - seen_q[idx];
  assign fresh_s = valid_q[idx] && (age_s <= stale_q);

  logic [31:0] page;
  logic pfresh;
  assign page = in_q.now_ms - seen_q[pair_q];
  assign pfresh = valid_q[pair_q] && (page <= stale_q);

  logic [IW-1:0] tgt;
  assign tgt = hit_q ? hit_idx_q : (free_q ? free_idx_q : old_idx_q);

  // Result words: a reject carries only its status; the finish step reports the
  // accept, or the paired peer of a query when one is left.
  ptrp_pkg::out_word_t rej_word, fin_word;
  always_comb begin
    rej_word = '0;
    rej_word.status = ptrp_pkg::ST_REJECT;
    fin_word = '0;
    if (in_q.command == ptrp_pkg::CMD_RX) begin
      fin_word.status = ptrp_pkg::ST_ACCEPT;
    end else if (!pair_ok_q || !pfresh) begin
      fin_word.status = ptrp_pkg::ST_NONE;
    end else begin
      fin_word.status = ptrp_pkg::ST_FOUND;
      fin_word.peer_mac = mac_q[pair_q];
      fin_word.peer_mood = mood_q[pair_q];
      fin_word.peer_has_style = style_q[pair_q][0];
      fin_word.tone_idx = style_q[pair_q][3:1];
      fin_word.hair_idx = style_q[pair_q][6:4];
      fin_word.iris_idx = style_q[pair_q][9:7];
      fin_word.beard_idx = style_q[pair_q][11:10];
      fin_word.glasses = style_q[pair_q][12];
      fin_word.peer_rssi = rssi_q[pair_q];
      fin_word.peer_age_ms = page;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      stale_q <= 32'd5000;
      hyst_q <= 7'd4;
      moodk_q <= 8'd8;
      valid_q <= '0;
      pair_ok_q <= 1'b0;
      pair_q <= '0;
      out_valid_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          ptrp_pkg::CFG_STALE: stale_q <= cfg_data_i;
          ptrp_pkg::CFG_HYST:  hyst_q <= cfg_data_i[6:0];
          ptrp_pkg::CFG_MOOD:  moodk_q <= cfg_data_i[7:0];
          default: ;
        endcase
      end
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      state_q <= state_d;
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i && in_ready_o) begin
            in_q <= in_data_i;
            style_in_q <= style_w;
            cnt_q <= '0;
            hit_q <= 1'b0; free_q <= 1'b0; best_ok_q <= 1'b0;
            old_t_q <= '1; old_idx_q <= '0; best_idx_q <= '0;
            best_r_q <= -8'sd128; best_age_q <= '1;
            if (in_data_i.command == ptrp_pkg::CMD_RX && reject) begin
              out_q <= rej_word;
            end
          end
        end
        S_SCAN: begin
          if (in_q.command == ptrp_pkg::CMD_RX) begin
            if (!hit_q && valid_q[idx] && mac_q[idx] == in_q.src_mac) begin
              hit_q <= 1'b1; hit_idx_q <= idx;
            end
            if (!free_q && !valid_q[idx]) begin
              free_q <= 1'b1; free_idx_q <= idx;
            end
            if (valid_q[idx] && seen_q[idx] < old_t_q) begin
              old_t_q <= seen_q[idx]; old_idx_q <= idx;
            end
          end else begin
            if (!fresh_s) valid_q[idx] <= 1'b0;
            else if (rssi_q[idx] > best_r_q ||
                     (rssi_q[idx] == best_r_q && age_s < best_age_q)) begin
              best_ok_q <= 1'b1; best_idx_q <= idx;
              best_r_q <= rssi_q[idx]; best_age_q <= age_s;
            end
          end
          cnt_q <= cnt_q + CW'(1);
        end
        S_WRITE: begin
          if (in_q.command == ptrp_pkg::CMD_RX) begin
            pair_fresh_q <= pair_ok_q && pfresh;
            valid_q[tgt] <= 1'b1;
            mac_q[tgt] <= in_q.src_mac;
            mood_q[tgt] <= in_q.mood_code;
            rssi_q[tgt] <= in_q.rx_rssi;
            style_q[tgt] <= style_in_q;
            seen_q[tgt] <= in_q.now_ms;
            hit_idx_q <= tgt;
          end else if (!pair_ok_q || !pfresh) begin
            pair_ok_q <= best_ok_q;
            pair_q <= best_idx_q;
          end
        end
        S_FIN: begin
          out_q <= fin_word;
          if (in_q.command == ptrp_pkg::CMD_RX) begin
            // The new entry is fresh by construction (age zero).
            if (!pair_fresh_q) begin
              pair_ok_q <= 1'b1; pair_q <= hit_idx_q;
            end else if (hit_idx_q != pair_q &&
                         10'($signed(in_q.rx_rssi)) >=
                         10'($signed(rssi_q[pair_q])) + 10'($signed({3'b0, hyst_q}))) begin
              pair_q <= hit_idx_q;
            end
          end
        end
        S_OUT: out_valid_q <= 1'b1;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_valid_i && in_ready_o)
        state_d = (in_data_i.command == ptrp_pkg::CMD_RX && reject) ? S_OUT : S_SCAN;
      S_SCAN: if (cnt_q == CW'(PEER_SLOTS - 1)) state_d = S_WRITE;
      S_WRITE: state_d = S_FIN;
      S_FIN: state_d = S_OUT;
      S_OUT: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> state_q == S_IDLE) else $error("ready outside idle");
  a_out_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_OUT) else $error("stray result");
  a_pair_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && in_q.command == ptrp_pkg::CMD_RX && out_q.status ==
     ptrp_pkg::ST_ACCEPT) |-> pair_ok_q) else $error("accepted frame left no pair");
endmodule
